// ===== rtl/mbr_pkg.sv =====
// ----------------------------------------------------------------------------
// mbr_pkg
// Types, address map constants and lane decode shared by the memory bus
// with reservations.
// ----------------------------------------------------------------------------
package mbr_pkg;

  typedef enum logic [0:0] {
    OpRead  = 1'b0,
    OpWrite = 1'b1
  } opcode_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CfgBpCount = 3'd0,
    CfgBpAddr0 = 3'd1,
    CfgBpAddr1 = 3'd2,
    CfgBpAddr2 = 3'd3,
    CfgBpAddr3 = 3'd4
  } cfg_idx_e;

  // Region whose read data feeds the response
  typedef enum logic [2:0] {
    RegNone    = 3'd0,
    RegMain    = 3'd1,
    RegScratch = 3'd2,
    RegRom     = 3'd3,
    RegVideo   = 3'd4
  } region_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [31:0] address;
    logic [31:0] write_data;
    logic [3:0]  byte_mask;
    logic        reserve_flag;
  } mbr_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        write_ok;
    logic        write_error_flag;
    logic        run_stop_flag;
    logic [31:0] led_value;
  } mbr_rsp_t;

  // Lane enables and data shift for one byte mask
  typedef struct packed {
    logic [3:0] be;
    logic [4:0] shift;
  } lane_t;

  localparam int unsigned SCRATCH_WORDS = 8192;
  localparam int unsigned ROM_WORDS     = 32768;
  localparam int unsigned VIDEO_WORDS   = 4096;
  localparam int unsigned ScratchAw     = $clog2(SCRATCH_WORDS);
  localparam int unsigned RomAw         = $clog2(ROM_WORDS);
  localparam int unsigned VideoAw       = $clog2(VIDEO_WORDS);

  // Address map
  localparam logic [31:0] MAIN_LIMIT   = 32'd134217728;
  localparam logic [11:0] SCRATCH_TAG  = 12'hFF4;
  localparam logic [31:0] ROM_MASK     = 32'hFFFC_0000;
  localparam logic [31:0] VIDEO_BASE   = 32'hFFD0_0000;
  localparam logic [31:0] LED_BASE     = 32'hFFDC_0600;
  localparam logic [31:0] PROT_LO      = 32'h0001_0000;
  localparam logic [31:0] PROT_HI      = 32'h0002_0000;

  // Multiply-with-carry generator
  localparam logic [15:0] GEN_Z_MUL    = 16'd36969;
  localparam logic [15:0] GEN_W_MUL    = 16'd18000;
  localparam logic [31:0] GEN_Z_RESET  = 32'd88888888;
  localparam logic [31:0] GEN_W_RESET  = 32'd12345678;

  function automatic lane_t mbr_lane_f(logic [3:0] mask);
    lane_t l;
    unique case (mask) inside
      4'd1, 4'd3, 4'd15: l = '{be: mask, shift: 5'd0};
      4'd2, 4'd6:        l = '{be: mask, shift: 5'd8};
      4'd4, 4'd12:       l = '{be: mask, shift: 5'd16};
      4'd8:              l = '{be: mask, shift: 5'd24};
      default:           l = '{be: 4'd0, shift: 5'd0};
    endcase
    return l;
  endfunction

endpackage

// ===== rtl/memory_bus_with_reservations.sv =====
// ----------------------------------------------------------------------------
// memory_bus_with_reservations
// Bus access unit with address decode, load-reserve / store-conditional,
// protected window, data breakpoints and an LED register.
// ----------------------------------------------------------------------------
// After reset the unit zeroes main and video memory, one word per cycle;
// input ready stays low until that pass is done, while configuration writes
// are taken at once. After that one access is taken per cycle: the access
// drives the memory port at the accept edge, the RAM registers the word read
// alongside the read stage, and the response then goes to the output register.
// Back-pressure on the response side stalls the input once the read stage and
// the output register are both full. MAIN_WORDS must be a power of two.
module memory_bus_with_reservations #(
  parameter int unsigned MAIN_WORDS  = 65536,
  parameter int unsigned BREAKPOINTS = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mbr_pkg::mbr_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mbr_pkg::mbr_rsp_t out_rsp_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i
);

  import mbr_pkg::*;

  localparam int unsigned MainAw = $clog2(MAIN_WORDS);

  // Configuration
  logic [2:0]  bp_count_q;
  logic [31:0] bp_addr_q [BREAKPOINTS];

  // Architectural state
  logic [31:0] rsv_a_q, rsv_a_d;
  logic [31:0] rsv_b_q, rsv_b_d;
  logic [31:0] gen_z_q, gen_z_d;
  logic [31:0] gen_w_q, gen_w_d;
  logic        err_q, err_d;
  logic        stop_q, stop_d;
  logic [31:0] led_q, led_d;

  // Clearing pass
  logic [MainAw-1:0] clr_cnt_q;
  logic              clr_done_q;

  // Read stage and output register
  logic        s1_valid_q;
  region_e     s1_sel_q, s1_sel_d;
  mbr_rsp_t    s1_rsp_q, s1_rsp_d;
  mbr_rsp_t    s1_out;
  logic        out_valid_q;
  mbr_rsp_t    out_rsp_q;
  logic        s1_adv, accept;

  // Decode
  logic [31:0] ad;
  logic        is_write, is_main, is_scratch, is_rom, is_video, is_led, is_prot;
  logic        cond_fail, wr_eff, bp_hit;
  lane_t       lane;
  logic [31:0] lane_data;

  // Memory ports
  logic              main_en, scr_en, rom_en, vid_en;
  logic [3:0]        main_be, scr_be, rom_be, vid_be;
  logic [MainAw-1:0] main_addr;
  logic [VideoAw-1:0] vid_addr;
  logic [31:0]       main_wdata, vid_wdata;
  logic [31:0]       main_rdata, scr_rdata, rom_rdata, vid_rdata;
  logic [31:0]       rd_word;

  assign cfg_ready_o = 1'b1;
  assign s1_adv      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = clr_done_q && (!s1_valid_q || s1_adv);
  assign accept      = in_valid_i && in_ready_o;

  assign ad         = in_req_i.address;
  assign is_write   = (in_req_i.opcode == OpWrite);
  assign is_main    = (ad < MAIN_LIMIT);
  assign is_scratch = (ad[31:20] == SCRATCH_TAG);
  assign is_rom     = ((ad & ROM_MASK) == ROM_MASK);
  assign is_video   = (ad[31:16] == VIDEO_BASE[31:16]);
  assign is_led     = (ad[31:8] == LED_BASE[31:8]);
  assign is_prot    = (ad >= PROT_LO) && (ad < PROT_HI);

  assign cond_fail = in_req_i.reserve_flag && (ad != rsv_a_q) && (ad != rsv_b_q);
  assign wr_eff    = is_write && !cond_fail;
  assign lane      = mbr_lane_f(in_req_i.byte_mask);
  assign lane_data = in_req_i.write_data << lane.shift;

  always_comb begin
    bp_hit = 1'b0;
    for (int n = 0; n < BREAKPOINTS; n++) begin
      if ((32'(n) < 32'(bp_count_q)) && (ad == bp_addr_q[n])) begin
        bp_hit = 1'b1;
      end
    end
  end

  // Step the state for one accepted access
  always_comb begin
    rsv_a_d  = rsv_a_q;
    rsv_b_d  = rsv_b_q;
    gen_z_d  = gen_z_q;
    gen_w_d  = gen_w_q;
    err_d    = err_q;
    stop_d   = stop_q;
    led_d    = led_q;
    s1_sel_d = RegNone;
    if (accept) begin
      if (!is_write) begin
        if (in_req_i.reserve_flag) begin
          if (rsv_a_q == 32'd0) begin
            rsv_a_d = ad;
          end else if (rsv_b_q == 32'd0) begin
            rsv_b_d = ad;
          end else begin
            gen_z_d = ({16'd0, GEN_Z_MUL} * {16'd0, gen_z_q[15:0]}) + {16'd0, gen_z_q[31:16]};
            gen_w_d = ({16'd0, GEN_W_MUL} * {16'd0, gen_w_q[15:0]}) + {16'd0, gen_w_q[31:16]};
            if (gen_w_d[0]) begin
              rsv_b_d = ad;
            end else begin
              rsv_a_d = ad;
            end
          end
        end
        if (is_main) begin
          s1_sel_d = RegMain;
        end else if (is_scratch) begin
          s1_sel_d = RegScratch;
        end else if (is_rom) begin
          s1_sel_d = RegRom;
        end else if (is_video) begin
          s1_sel_d = RegVideo;
        end
      end else begin
        if (wr_eff) begin
          if (in_req_i.reserve_flag) begin
            if (ad == rsv_a_q) rsv_a_d = 32'd0;
            if (ad == rsv_b_q) rsv_b_d = 32'd0;
          end
          if (is_main && is_prot) begin
            err_d = 1'b1;
          end else if (!is_main && !is_scratch && is_led) begin
            led_d = in_req_i.write_data;
          end
        end
        if (bp_hit) stop_d = 1'b1;
      end
    end
  end

  always_comb begin
    s1_rsp_d                  = '0;
    s1_rsp_d.write_ok         = wr_eff;
    s1_rsp_d.write_error_flag = err_d;
    s1_rsp_d.run_stop_flag    = stop_d;
    s1_rsp_d.led_value        = led_d;
  end

  // Memory port drive: clearing pass first, then accesses
  always_comb begin
    main_en    = 1'b0;
    main_be    = 4'd0;
    main_addr  = ad[MainAw+1:2];
    main_wdata = lane_data;
    vid_en     = 1'b0;
    vid_be     = 4'd0;
    vid_addr   = ad[VideoAw+1:2];
    vid_wdata  = in_req_i.write_data;
    scr_en     = 1'b0;
    scr_be     = 4'd0;
    rom_en     = 1'b0;
    rom_be     = 4'd0;
    if (!clr_done_q) begin
      main_en    = 1'b1;
      main_be    = 4'hF;
      main_addr  = clr_cnt_q;
      main_wdata = 32'd0;
      vid_en     = 1'b1;
      vid_be     = 4'hF;
      vid_addr   = clr_cnt_q[VideoAw-1:0];
      vid_wdata  = 32'd0;
    end else if (accept) begin
      if (!is_write) begin
        main_en = is_main;
        scr_en  = !is_main && is_scratch;
        rom_en  = !is_main && !is_scratch && is_rom;
        vid_en  = !is_main && !is_scratch && !is_rom && is_video;
      end else if (wr_eff) begin
        if (is_main) begin
          main_en = !is_prot;
          main_be = lane.be;
        end else if (is_scratch) begin
          scr_en = 1'b1;
          scr_be = lane.be;
        end else if (!is_led && is_rom) begin
          rom_en = 1'b1;
          rom_be = 4'hF;
        end else if (!is_led && is_video) begin
          vid_en = 1'b1;
          vid_be = 4'hF;
        end
      end
    end
  end

  mbr_ram #(.WORDS(MAIN_WORDS)) u_main (
    .clk_i   (clk_i),
    .en_i    (main_en),
    .be_i    (main_be),
    .addr_i  (main_addr),
    .wdata_i (main_wdata),
    .rdata_o (main_rdata)
  );

  mbr_ram #(.WORDS(SCRATCH_WORDS)) u_scratch (
    .clk_i   (clk_i),
    .en_i    (scr_en),
    .be_i    (scr_be),
    .addr_i  (ad[ScratchAw+1:2]),
    .wdata_i (lane_data),
    .rdata_o (scr_rdata)
  );

  mbr_ram #(.WORDS(ROM_WORDS)) u_rom (
    .clk_i   (clk_i),
    .en_i    (rom_en),
    .be_i    (rom_be),
    .addr_i  (ad[RomAw+1:2]),
    .wdata_i (in_req_i.write_data),
    .rdata_o (rom_rdata)
  );

  mbr_ram #(.WORDS(VIDEO_WORDS)) u_video (
    .clk_i   (clk_i),
    .en_i    (vid_en),
    .be_i    (vid_be),
    .addr_i  (vid_addr),
    .wdata_i (vid_wdata),
    .rdata_o (vid_rdata)
  );

  always_comb begin
    unique case (s1_sel_q)
      RegMain:    rd_word = main_rdata;
      RegScratch: rd_word = scr_rdata;
      RegRom:     rd_word = rom_rdata;
      RegVideo:   rd_word = vid_rdata;
      default:    rd_word = 32'd0;
    endcase
  end

  always_comb begin
    s1_out           = s1_rsp_q;
    s1_out.read_data = rd_word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bp_count_q <= 3'd0;
      for (int n = 0; n < BREAKPOINTS; n++) begin
        bp_addr_q[n] <= 32'd0;
      end
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgBpCount) begin
        bp_count_q <= cfg_data_i[2:0];
      end
      for (int n = 0; n < BREAKPOINTS; n++) begin
        if (cfg_index_i == 3'(n + 1)) begin
          bp_addr_q[n] <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsv_a_q    <= 32'd0;
      rsv_b_q    <= 32'd0;
      gen_z_q    <= GEN_Z_RESET;
      gen_w_q    <= GEN_W_RESET;
      err_q      <= 1'b0;
      stop_q     <= 1'b0;
      led_q      <= 32'd0;
      clr_cnt_q  <= '0;
      clr_done_q <= 1'b0;
    end else begin
      rsv_a_q <= rsv_a_d;
      rsv_b_q <= rsv_b_d;
      gen_z_q <= gen_z_d;
      gen_w_q <= gen_w_d;
      err_q   <= err_d;
      stop_q  <= stop_d;
      led_q   <= led_d;
      if (!clr_done_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == MainAw'(MAIN_WORDS - 1)) begin
          clr_done_q <= 1'b1;
        end
      end
    end
  end

  // Read stage: hold the access until the registered memory word is available
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sel_q <= s1_sel_d;
      s1_rsp_q <= s1_rsp_d;
    end
    if (s1_adv) begin
      out_rsp_q <= s1_out;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// ===== rtl/mbr_ram.sv =====
// ----------------------------------------------------------------------------
// mbr_ram
// Single-port synchronous RAM with byte write enables and a registered read.
// ----------------------------------------------------------------------------
module mbr_ram #(
  parameter int unsigned WORDS = 4096
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [3:0]               be_i,
  input  logic [$clog2(WORDS)-1:0] addr_i,
  input  logic [31:0]              wdata_i,
  output logic [31:0]              rdata_o
);

  logic [31:0] mem [WORDS];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int b = 0; b < 4; b++) begin
        if (be_i[b]) begin
          mem[addr_i][8*b +: 8] <= wdata_i[8*b +: 8];
        end
      end
    end
  end

  // Read only when no lane is written; hold the last read word otherwise
  always_ff @(posedge clk_i) begin
    if (en_i && (be_i == 4'd0)) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
